>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the highlighter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tmth_pkg.sv
// ---------------------------------------------------------------------------
// tmth_pkg
// Types, codes and helpers shared by the TeX token highlighter modules.
// ---------------------------------------------------------------------------
package tmth_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RES     = 4;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = 3;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [2:0] S_COMMENT = 3'd0;
  localparam logic [2:0] S_WARNING = 3'd1;
  localparam logic [2:0] S_RESET   = 3'd2;
  localparam logic [2:0] S_KEYWORD = 3'd3;
  localparam logic [2:0] S_ESCAPE  = 3'd4;
  localparam logic [2:0] S_MATH    = 3'd5;
  localparam logic [2:0] S_STRING  = 3'd6;

  localparam logic [31:0] CH_BSL    = 32'h0000_005C;
  localparam logic [31:0] CH_DOLLAR = 32'h0000_0024;
  localparam logic [31:0] CH_TICK   = 32'h0000_0060;
  localparam logic [31:0] CH_PCT    = 32'h0000_0025;
  localparam logic [31:0] CH_QUOTE  = 32'h0000_0027;
  localparam logic [31:0] CH_AT     = 32'h0000_0040;
  localparam logic [31:0] CH_NL     = 32'h0000_000A;
  localparam logic [31:0] CH_SPACE  = 32'h0000_0020;
  localparam logic [31:0] CP_BOM    = 32'h0000_FEFF;

  typedef struct packed {
    logic        kind;
    logic [31:0] code_point;
    logic [2:0]  style;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    res_t [MAX_RES-1:0]     ent;
  } bundle_t;

  function automatic res_t char_res(input logic [31:0] c);
    res_t r;
    r.kind       = KIND_CHAR;
    r.code_point = c;
    r.style      = 3'd0;
    return r;
  endfunction

  function automatic res_t mark_res(input logic [2:0] s);
    res_t r;
    r.kind       = KIND_MARK;
    r.code_point = 32'd0;
    r.style      = s;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [31:0] c);
    return c inside {[32'h61:32'h7A], [32'h41:32'h5A]};
  endfunction

  function automatic logic is_space(input logic [31:0] c);
    return (c == CH_SPACE) || (c inside {[32'h09:32'h0D]});
  endfunction

endpackage

>>> design/tmth_queue.sv
// ---------------------------------------------------------------------------
// tmth_queue
// Short bundle queue between the lexer front end and the result serializer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmth_queue #(
  parameter int DEPTH = tmth_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  tmth_pkg::bundle_t wr_data,
  input  logic              rd_en,
  output logic              full,
  output logic              empty,
  output tmth_pkg::bundle_t head
);
  import tmth_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "queue count overrun")
  `ASSERT_NXT(a_count_inc, clk, rst_n, wr_en && !rd_en, count_r == $past(count_r) + 1'b1, "queue count lost a write")

endmodule

>>> design/tmth_front.sv
// ---------------------------------------------------------------------------
// tmth_front
// UTF-8 decoder and ten-mode TeX lexer; emits at most one result bundle per item.
// ---------------------------------------------------------------------------
module tmth_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  output logic              wr_en,
  output tmth_pkg::bundle_t bundle
);
  import tmth_pkg::*;

  localparam logic [3:0] M_NORMAL  = 4'd0;
  localparam logic [3:0] M_BSL     = 4'd1;
  localparam logic [3:0] M_CMD     = 4'd2;
  localparam logic [3:0] M_COMMENT = 4'd3;
  localparam logic [3:0] M_DOLLAR  = 4'd4;
  localparam logic [3:0] M_MATH    = 4'd5;
  localparam logic [3:0] M_MBSL    = 4'd6;
  localparam logic [3:0] M_TICK    = 4'd7;
  localparam logic [3:0] M_STR     = 4'd8;
  localparam logic [3:0] M_STRQ    = 4'd9;

  logic [3:0]  mode_r, mode_nxt;
  logic [31:0] partial_r, partial_nxt;
  logic [2:0]  pending_r, pending_nxt;

  logic [31:0] part_shift;
  logic [31:0] c;
  logic        have;

  logic [3:0]       nrm_mode;
  logic [CNT_W-1:0] nrm_n;
  res_t             nrm0, nrm1;

  logic [CNT_W-1:0]   cnt;
  res_t [MAX_RES-1:0] ent;

  assign part_shift = {partial_r[25:0], data_byte[5:0]};

  // UTF-8 assembly
  always_comb begin
    have        = 1'b1;
    c           = {24'd0, data_byte};
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    if (cmd) begin
      have        = 1'b0;
      pending_nxt = 3'd0;
      partial_nxt = 32'd0;
    end else if (pending_r == 3'd0) begin
      if (data_byte >= 8'hC0) begin
        have = 1'b0;
        if (data_byte inside {[8'hC0:8'hDF]}) begin
          partial_nxt = {24'd0, data_byte & 8'h1F};
          pending_nxt = 3'd1;
        end else if (data_byte inside {[8'hE0:8'hEF]}) begin
          partial_nxt = {24'd0, data_byte & 8'h0F};
          pending_nxt = 3'd2;
        end else if (data_byte inside {[8'hF0:8'hF7]}) begin
          partial_nxt = {24'd0, data_byte & 8'h07};
          pending_nxt = 3'd3;
        end else if (data_byte inside {[8'hF8:8'hFB]}) begin
          partial_nxt = {24'd0, data_byte & 8'h03};
          pending_nxt = 3'd4;
        end else if (data_byte inside {[8'hFC:8'hFD]}) begin
          partial_nxt = {24'd0, data_byte & 8'h03};
          pending_nxt = 3'd5;
        end else begin
          partial_nxt = {24'd0, data_byte & 8'h03};
          pending_nxt = 3'd6;
        end
      end
    end else if (data_byte[7:6] == 2'b10) begin
      partial_nxt = part_shift;
      c           = part_shift;
      pending_nxt = pending_r - 3'd1;
      if (pending_r != 3'd1) begin
        have = 1'b0;
      end
    end else begin
      pending_nxt = 3'd0;
    end
  end

  // normal-mode handling of c
  always_comb begin
    nrm_mode = M_NORMAL;
    nrm_n    = CNT_W'(1);
    nrm0     = char_res(c);
    nrm1     = '0;
    if (c == CH_BSL) begin
      nrm_mode = M_BSL;
      nrm_n    = '0;
    end else if (c == CH_DOLLAR) begin
      nrm_mode = M_DOLLAR;
      nrm_n    = '0;
    end else if (c == CH_TICK) begin
      nrm_mode = M_TICK;
      nrm_n    = '0;
    end else if (c == CH_PCT) begin
      nrm_mode = M_COMMENT;
      nrm_n    = CNT_W'(2);
      nrm0     = mark_res(S_COMMENT);
      nrm1     = char_res(CH_PCT);
    end
  end

  // lexer
  always_comb begin
    mode_nxt = mode_r;
    cnt      = '0;
    ent      = '0;
    if (cmd) begin
      mode_nxt = M_NORMAL;
      case (mode_r)
        M_TICK: begin
          ent[0] = char_res(CH_TICK);
          cnt    = CNT_W'(1);
        end
        M_DOLLAR: begin
          ent[0] = char_res(CH_DOLLAR);
          cnt    = CNT_W'(1);
        end
        M_BSL: begin
          ent[0] = char_res(CH_BSL);
          cnt    = CNT_W'(1);
        end
        M_CMD, M_COMMENT, M_MATH, M_MBSL, M_STR, M_STRQ: begin
          ent[0] = mark_res(S_RESET);
          cnt    = CNT_W'(1);
        end
        default: begin
          cnt = '0;
        end
      endcase
    end else if (have && (c != CP_BOM)) begin
      case (mode_r)
        M_BSL: begin
          if (c == CH_BSL) begin
            ent[0]   = mark_res(S_WARNING);
            ent[1]   = char_res(CH_BSL);
            ent[2]   = char_res(CH_BSL);
            ent[3]   = mark_res(S_RESET);
            cnt      = CNT_W'(4);
            mode_nxt = M_NORMAL;
          end else if (is_space(c)) begin
            ent[0]   = char_res(CH_BSL);
            ent[1]   = nrm0;
            ent[2]   = nrm1;
            cnt      = nrm_n + 1'b1;
            mode_nxt = nrm_mode;
          end else if (is_alpha(c) || (c == CH_AT)) begin
            ent[0]   = mark_res(S_KEYWORD);
            ent[1]   = char_res(CH_BSL);
            ent[2]   = char_res(c);
            cnt      = CNT_W'(3);
            mode_nxt = M_CMD;
          end else begin
            ent[0]   = mark_res(S_ESCAPE);
            ent[1]   = char_res(CH_BSL);
            ent[2]   = char_res(c);
            ent[3]   = mark_res(S_RESET);
            cnt      = CNT_W'(4);
            mode_nxt = M_NORMAL;
          end
        end
        M_CMD: begin
          if (is_alpha(c) || (c == CH_AT)) begin
            ent[0] = char_res(c);
            cnt    = CNT_W'(1);
          end else begin
            ent[0]   = mark_res(S_RESET);
            ent[1]   = nrm0;
            ent[2]   = nrm1;
            cnt      = nrm_n + 1'b1;
            mode_nxt = nrm_mode;
          end
        end
        M_DOLLAR: begin
          if (c == CH_DOLLAR) begin
            ent[0]   = char_res(CH_DOLLAR);
            ent[1]   = char_res(CH_DOLLAR);
            cnt      = CNT_W'(2);
            mode_nxt = M_NORMAL;
          end else if (c == CH_BSL) begin
            ent[0]   = mark_res(S_MATH);
            ent[1]   = char_res(CH_DOLLAR);
            ent[2]   = char_res(CH_BSL);
            cnt      = CNT_W'(3);
            mode_nxt = M_MBSL;
          end else begin
            ent[0]   = mark_res(S_MATH);
            ent[1]   = char_res(CH_DOLLAR);
            ent[2]   = char_res(c);
            cnt      = CNT_W'(3);
            mode_nxt = M_MATH;
          end
        end
        M_MATH: begin
          if (c == CH_DOLLAR) begin
            ent[0]   = char_res(CH_DOLLAR);
            ent[1]   = mark_res(S_RESET);
            cnt      = CNT_W'(2);
            mode_nxt = M_NORMAL;
          end else if (c == CH_BSL) begin
            ent[0]   = char_res(CH_BSL);
            cnt      = CNT_W'(1);
            mode_nxt = M_MBSL;
          end else begin
            ent[0] = char_res(c);
            cnt    = CNT_W'(1);
          end
        end
        M_MBSL: begin
          ent[0]   = char_res(c);
          cnt      = CNT_W'(1);
          mode_nxt = M_MATH;
        end
        M_COMMENT: begin
          ent[0] = char_res(c);
          cnt    = CNT_W'(1);
          if (c == CH_NL) begin
            ent[1]   = mark_res(S_RESET);
            cnt      = CNT_W'(2);
            mode_nxt = M_NORMAL;
          end
        end
        M_TICK: begin
          if (c == CH_TICK) begin
            ent[0]   = mark_res(S_STRING);
            ent[1]   = char_res(CH_TICK);
            ent[2]   = char_res(CH_TICK);
            cnt      = CNT_W'(3);
            mode_nxt = M_STR;
          end else begin
            ent[0]   = char_res(CH_TICK);
            ent[1]   = nrm0;
            ent[2]   = nrm1;
            cnt      = nrm_n + 1'b1;
            mode_nxt = nrm_mode;
          end
        end
        M_STR: begin
          ent[0] = char_res(c);
          cnt    = CNT_W'(1);
          if (c == CH_QUOTE) begin
            mode_nxt = M_STRQ;
          end
        end
        M_STRQ: begin
          ent[0] = char_res(c);
          cnt    = CNT_W'(1);
          if (c == CH_QUOTE) begin
            ent[1]   = mark_res(S_RESET);
            cnt      = CNT_W'(2);
            mode_nxt = M_NORMAL;
          end else begin
            mode_nxt = M_STR;
          end
        end
        default: begin
          ent[0]   = nrm0;
          ent[1]   = nrm1;
          cnt      = nrm_n;
          mode_nxt = nrm_mode;
        end
      endcase
    end
  end

  assign wr_en      = accept && (cnt != '0);
  assign bundle.cnt = cnt;
  assign bundle.ent = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_NORMAL;
      partial_r <= 32'd0;
      pending_r <= 3'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

>>> design/tmth_back.sv
// ---------------------------------------------------------------------------
// tmth_back
// Result serializer: walks each queued bundle into the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmth_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tmth_pkg::bundle_t head,
  output logic              rd_en,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_kind,
  output logic [31:0]       out_code_point,
  output logic [2:0]        out_style,
  output logic              out_last
);
  import tmth_pkg::*;

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic             kind_r, last_r;
  logic [31:0]      cp_r;
  logic [2:0]       style_r;
  logic             load, take, is_last;
  res_t             cur;

  assign idx_ext = CNT_W'(idx_r);
  assign cur     = head.ent[idx_r];
  assign is_last = (idx_ext == head.cnt - 1'b1);
  assign load    = !valid_r || out_pop;
  assign take    = load && !q_empty;
  assign rd_en   = take && is_last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (take) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? '0 : idx_r + 1'b1;
    end else if (load) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= cur.kind;
      cp_r    <= cur.code_point;
      style_r <= cur.style;
      last_r  <= is_last;
    end
  end

  assign out_empty      = !valid_r;
  assign out_kind       = kind_r;
  assign out_code_point = cp_r;
  assign out_style      = style_r;
  assign out_last       = last_r;

  `ASSERT_IMP(a_idx_in_bundle, clk, rst_n, !q_empty, idx_ext < head.cnt, "index past bundle end")
  `ASSERT_IMP(a_idx_idle, clk, rst_n, q_empty, idx_r == '0, "index left over with empty queue")
  `ASSERT_NXT(a_out_hold, clk, rst_n, valid_r && !out_pop, valid_r && $stable(cp_r) && $stable(last_r), "output changed while stalled")

endmodule

>>> design/tex_markup_token_highlighter.sv
// ---------------------------------------------------------------------------
// tex_markup_token_highlighter
// Throughput: one item accepted per cycle while the bundle queue has room;
//   results leave one per cycle while out_pop takes them; an item yields
//   from 0 to 4 results.
// With queue and output idle, the edge that accepts an item writes the
//   queue, and the serializer then loads its first result onto the out_
//   ports. Reset (rst_n low, synchronous) returns the lexer to normal
//   mode, drops any pending sequence and empties queue and output.
// ---------------------------------------------------------------------------
module tex_markup_token_highlighter #(
  parameter int QUEUE_DEPTH = tmth_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [31:0] out_code_point,
  output logic [2:0]  out_style,
  output logic        out_last
);
  import tmth_pkg::*;

  logic    accept;
  logic    wr_en, rd_en, q_full, q_empty;
  bundle_t wr_bundle, head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  tmth_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_cmd),
    .data_byte (in_data_byte),
    .wr_en     (wr_en),
    .bundle    (wr_bundle)
  );

  tmth_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_bundle),
    .rd_en   (rd_en),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  tmth_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (head),
    .rd_en          (rd_en),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_kind       (out_kind),
    .out_code_point (out_code_point),
    .out_style      (out_style),
    .out_last       (out_last)
  );

endmodule
